FILE: rtl/utf8d_pkg.sv
package utf8d_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned UNIT_W    = 16;
    localparam int unsigned PAYLOAD_W = 21;
    localparam int unsigned MAX_UNITS = 3;
    localparam int unsigned CNT_W     = 2;

    localparam logic [UNIT_W-1:0]    BAD_UNIT    = 16'h003F;
    localparam logic [UNIT_W-1:0]    TERM_UNIT   = 16'h0000;
    localparam logic [UNIT_W-1:0]    HI_SURR     = 16'hD800;
    localparam logic [UNIT_W-1:0]    HI_SURR_MAX = 16'hDBFF;
    localparam logic [5:0]           LO_SURR_TOP = 6'b110111;
    localparam logic [31:0]          PLANE_BASE  = 32'h0001_0000;

    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;
    localparam logic [2:0] LEN_5 = 3'd5;
    localparam logic [2:0] LEN_6 = 3'd6;

    typedef struct packed {
        logic [MAX_UNITS-1:0][UNIT_W-1:0] unit;
        logic [CNT_W-1:0]                 count;
        logic                             cesu;
        logic                             fin;
    } t_bundle;

endpackage

FILE: rtl/utf8_to_utf16_decoder.sv
// A byte's units are registered; they appear from the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one unit and the
// master side is ready; a byte that gives several units holds the output register
// until all are taken, and the next byte is taken in the cycle the last is taken.
// Reset: synchronous, active low; clears the decoder state and the output valid flag.
module utf8_to_utf16_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] data_byte
    input  logic [utf8d_pkg::BYTE_W-1:0]   i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [15:0] code_unit
    output logic [utf8d_pkg::UNIT_W-1:0]   o_m_axis_tdata,
    // [0] cesu_seen
    output logic                           o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import utf8d_pkg::*;

    t_bundle          w_bundle;
    t_bundle          r_bundle;
    logic             r_valid;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             w_accept;
    logic             w_last_unit;
    logic             w_out_take;

    assign w_last_unit     = (r_idx == r_bundle.count - 1'b1);
    assign w_out_take      = r_valid && i_m_axis_tready;
    assign o_s_axis_tready = !r_valid || (w_out_take && w_last_unit);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    utf8d_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_fin    (i_s_axis_tlast),
        .o_bundle (w_bundle)
    );

    always_comb begin
        n_idx = r_idx;
        if (w_accept) begin
            n_idx = '0;
        end else if (w_out_take) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (w_accept) begin
                r_valid <= (w_bundle.count != '0);
            end else if (w_out_take && w_last_unit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bundle <= w_bundle;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_bundle.unit[r_idx];
    assign o_m_axis_tuser  = r_bundle.cesu;
    assign o_m_axis_tlast  = r_bundle.fin && w_last_unit;

endmodule

FILE: rtl/utf8d_core.sv
module utf8d_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [utf8d_pkg::BYTE_W-1:0]  i_byte,
    input  logic                          i_fin,
    output utf8d_pkg::t_bundle            o_bundle
);
    import utf8d_pkg::*;

    logic [2:0]           r_exp, n_exp;
    logic [2:0]           r_len, n_len;
    logic [PAYLOAD_W-1:0] r_gath, n_gath;
    logic                 r_skip, n_skip;
    logic                 r_cesu, n_cesu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= '0;
            r_len  <= '0;
            r_gath <= '0;
            r_skip <= 1'b0;
            r_cesu <= 1'b0;
        end else if (i_accept) begin
            r_exp  <= n_exp;
            r_len  <= n_len;
            r_gath <= n_gath;
            r_skip <= n_skip;
            r_cesu <= n_cesu;
        end
    end

    always_comb begin
        logic                 cont;
        logic                 fresh;
        logic [2:0]           e;
        logic [PAYLOAD_W-1:0] g;
        logic [31:0]          x;
        logic [CNT_W-1:0]     k;
        logic [UNIT_W-1:0]    u3;

        n_exp  = r_exp;
        n_len  = r_len;
        n_gath = r_gath;
        n_skip = r_skip;
        n_cesu = r_cesu;
        o_bundle = '0;
        k     = '0;
        fresh = 1'b0;
        cont  = (i_byte[7:6] == 2'b10);
        g     = {r_gath[PAYLOAD_W-7:0], i_byte[5:0]};
        e     = r_exp - 3'd1;
        x     = {11'b0, g} - PLANE_BASE;
        u3    = g[UNIT_W-1:0];

        if (r_exp != 3'd0) begin
            if (cont) begin
                n_gath = g;
                n_exp  = e;
                if (e == 3'd0) begin
                    case (r_len)
                        LEN_2: begin
                            o_bundle.unit[k] = {5'b0, g[10:0]};
                            k = k + 1'b1;
                        end
                        LEN_3: begin
                            if (u3 inside {[HI_SURR:HI_SURR_MAX]}) begin
                                n_cesu = 1'b1;
                            end
                            o_bundle.unit[k] = u3;
                            k = k + 1'b1;
                        end
                        LEN_4: begin
                            o_bundle.unit[k] = x[25:10] + HI_SURR;
                            k = k + 1'b1;
                            o_bundle.unit[k] = {LO_SURR_TOP, x[9:0]};
                            k = k + 1'b1;
                        end
                        default: begin
                            o_bundle.unit[k] = BAD_UNIT;
                            k = k + 1'b1;
                        end
                    endcase
                    n_exp  = '0;
                    n_len  = '0;
                    n_gath = '0;
                end else if (i_fin) begin
                    o_bundle.unit[k] = BAD_UNIT;
                    k = k + 1'b1;
                end
            end else begin
                o_bundle.unit[k] = BAD_UNIT;
                k = k + 1'b1;
                n_exp  = '0;
                n_len  = '0;
                n_gath = '0;
                n_skip = 1'b0;
                fresh  = 1'b1;
            end
        end else if (!(r_skip && cont)) begin
            n_skip = 1'b0;
            fresh  = 1'b1;
        end

        if (fresh) begin
            if (!i_byte[7]) begin
                o_bundle.unit[k] = {8'b0, i_byte};
                k = k + 1'b1;
            end else if (cont || i_byte inside {[8'hFE:8'hFF]}) begin
                o_bundle.unit[k] = BAD_UNIT;
                k = k + 1'b1;
                n_skip = 1'b1;
            end else if (i_fin) begin
                o_bundle.unit[k] = BAD_UNIT;
                k = k + 1'b1;
            end else begin
                if (i_byte inside {[8'hC0:8'hDF]}) begin
                    n_len  = LEN_2;
                    n_gath = {16'b0, i_byte[4:0]};
                end else if (i_byte inside {[8'hE0:8'hEF]}) begin
                    n_len  = LEN_3;
                    n_gath = {17'b0, i_byte[3:0]};
                end else if (i_byte inside {[8'hF0:8'hF7]}) begin
                    n_len  = LEN_4;
                    n_gath = {18'b0, i_byte[2:0]};
                end else if (i_byte inside {[8'hF8:8'hFB]}) begin
                    n_len  = LEN_5;
                    n_gath = '0;
                end else begin
                    n_len  = LEN_6;
                    n_gath = '0;
                end
                n_exp = n_len - 3'd1;
            end
        end

        o_bundle.cesu = n_cesu;
        o_bundle.fin  = i_fin;

        if (i_fin) begin
            o_bundle.unit[k] = TERM_UNIT;
            k = k + 1'b1;
            n_exp  = '0;
            n_len  = '0;
            n_gath = '0;
            n_skip = 1'b0;
            n_cesu = 1'b0;
        end

        o_bundle.count = k;
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import utf8d_pkg::*;

    localparam int unsigned  CYCLE_LIMIT  = 200000;
    localparam logic [15:0]  LO_SURR_BASE = 16'hDC00;

    typedef struct {
        logic [UNIT_W-1:0] code;
        logic              cesu;
        logic              eos;
    } t_utf16_unit;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid = 1'b0;
    logic [BYTE_W-1:0]  s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [UNIT_W-1:0]  m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    t_utf16_unit        units_due[$];
    logic [7:0]         text[$];

    // Decoder state as the predictor sees it.
    logic [2:0]         pend_cont = '0;
    logic [2:0]         seq_len = '0;
    logic [20:0]        payload = '0;
    logic               skip_cont = 1'b0;
    logic               cesu_sticky = 1'b0;

    bit                 calm = 1'b0;
    int                 long_hold_req = 0;
    int                 mismatches = 0;
    int                 bytes_sent = 0;
    int                 strings_sent = 0;
    int                 units_checked = 0;
    int                 cesu_units = 0;
    int                 cycles = 0;

    utf8_to_utf16_decoder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
    end

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d units outstanding.",
                     cycles, units_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void push_unit(logic [UNIT_W-1:0] code, logic eos);
        t_utf16_unit u;
        u.code = code;
        u.cesu = cesu_sticky;
        u.eos  = eos;
        units_due.push_back(u);
    endfunction

    function automatic void clear_sequence();
        pend_cont = '0;
        seq_len   = '0;
        payload   = '0;
    endfunction

    function automatic void close_sequence();
        logic [31:0] ofs;
        case (seq_len)
            LEN_2: begin
                push_unit({5'd0, payload[10:0]}, 1'b0);
            end
            LEN_3: begin
                if (payload[15:0] >= HI_SURR && payload[15:0] <= HI_SURR_MAX) begin
                    cesu_sticky = 1'b1;
                end
                push_unit(payload[15:0], 1'b0);
            end
            LEN_4: begin
                ofs = {11'd0, payload} - PLANE_BASE;
                push_unit(ofs[25:10] + HI_SURR, 1'b0);
                push_unit({6'd0, ofs[9:0]} + LO_SURR_BASE, 1'b0);
            end
            default: begin
                push_unit(BAD_UNIT, 1'b0);
            end
        endcase
        clear_sequence();
    endfunction

    function automatic void open_byte(logic [7:0] b, logic fin);
        if (b < 8'h80) begin
            push_unit({8'd0, b}, 1'b0);
        end else if (b[7:6] == 2'b10 || b >= 8'hFE) begin
            push_unit(BAD_UNIT, 1'b0);
            skip_cont = 1'b1;
        end else if (fin) begin
            push_unit(BAD_UNIT, 1'b0);
        end else begin
            if (b < 8'hE0) begin
                seq_len = LEN_2;
                payload = {16'd0, b[4:0]};
            end else if (b < 8'hF0) begin
                seq_len = LEN_3;
                payload = {17'd0, b[3:0]};
            end else if (b < 8'hF8) begin
                seq_len = LEN_4;
                payload = {18'd0, b[2:0]};
            end else if (b < 8'hFC) begin
                seq_len = LEN_5;
                payload = '0;
            end else begin
                seq_len = LEN_6;
                payload = '0;
            end
            pend_cont = seq_len - 3'd1;
        end
    endfunction

    function automatic void decode_utf8_byte(logic [7:0] b, logic fin);
        logic cont;
        cont = (b[7:6] == 2'b10);
        if (pend_cont != 0) begin
            if (cont) begin
                payload   = {payload[14:0], b[5:0]};
                pend_cont = pend_cont - 3'd1;
                if (pend_cont == 0) begin
                    close_sequence();
                end else if (fin) begin
                    push_unit(BAD_UNIT, 1'b0);
                end
            end else begin
                push_unit(BAD_UNIT, 1'b0);
                clear_sequence();
                skip_cont = 1'b0;
                open_byte(b, fin);
            end
        end else if (!(skip_cont && cont)) begin
            skip_cont = 1'b0;
            open_byte(b, fin);
        end
        if (fin) begin
            push_unit(TERM_UNIT, 1'b1);
            clear_sequence();
            skip_cont   = 1'b0;
            cesu_sticky = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR at %0t: %s got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin : check_units
        t_utf16_unit want;
        if (rst_n && m_tvalid && m_tready) begin
            if (units_due.size() == 0) begin
                report_mismatch("unexpected unit", m_tdata, 16'hxxxx);
            end else begin
                want = units_due.pop_front();
                if (m_tdata !== want.code) begin
                    report_mismatch("code_unit", m_tdata, want.code);
                end
                if (m_tuser !== want.cesu) begin
                    report_mismatch("cesu_seen", {15'd0, m_tuser}, {15'd0, want.cesu});
                end
                if (m_tlast !== want.eos) begin
                    report_mismatch("end_of_string", {15'd0, m_tlast}, {15'd0, want.eos});
                end
                units_checked++;
                if (want.cesu) begin
                    cesu_units++;
                end
            end
        end
    end

    initial begin : sink_ready
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req > 0) begin
                hold_left = long_hold_req - 1;
                long_hold_req = 0;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        decode_utf8_byte(b, fin);
        bytes_sent++;
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
    endtask

    task automatic send_text();
        foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
        end
        text.delete();
        strings_sent++;
    endtask

    task automatic add_sequence(input int len);
        logic [7:0] lead;
        bit         cesu_pick;
        cesu_pick = 1'b0;
        case (len)
            1: lead = 8'($urandom_range(8'h00, 8'h7F));
            2: lead = 8'($urandom_range(8'hC0, 8'hDF));
            3: begin
                cesu_pick = ($urandom_range(0, 3) == 0);
                lead = cesu_pick ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
            end
            4: lead = 8'($urandom_range(8'hF0, 8'hF7));
            5: lead = 8'($urandom_range(8'hF8, 8'hFB));
            default: lead = 8'($urandom_range(8'hFC, 8'hFD));
        endcase
        text.push_back(lead);
        for (int i = 1; i < len; i++) begin
            if (cesu_pick && i == 1) begin
                text.push_back(8'($urandom_range(8'hA0, 8'hAF)));
            end else begin
                text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
        end
    endtask

    task automatic add_noise();
        int len;
        case ($urandom_range(0, 3))
            0: text.push_back(8'($urandom_range(0, 255)));
            1: begin
                len = $urandom_range(2, 6);
                add_sequence(len);
                repeat ($urandom_range(1, len - 1)) void'(text.pop_back());
            end
            2: begin
                repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            default: text.push_back(8'($urandom_range(8'hFE, 8'hFF)));
        endcase
    endtask

    task automatic drain_units();
        s_tvalid <= 1'b0;
        while (units_due.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        logic [7:0] probe [0:24];
        probe = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hED, 8'hA0, 8'h80,
                  8'hF0, 8'h80, 8'h80, 8'h80,
                  8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                  8'h80, 8'hBF, 8'h41, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82};
        foreach (probe[i]) begin
            text.push_back(probe[i]);
        end
        send_text();
    endtask

    task automatic test_output_backpressure();
        long_hold_req = 120;
        repeat (40) add_sequence(1);
        send_text();
    endtask

    task automatic test_random_strings(input int target_bytes);
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < target_bytes) begin
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 9) < 8) begin
                    r = $urandom_range(0, 9);
                    if (r < 3) add_sequence(1);
                    else if (r < 5) add_sequence(2);
                    else if (r < 7) add_sequence(3);
                    else if (r < 9) add_sequence(4);
                    else add_sequence($urandom_range(5, 6));
                end else begin
                    add_noise();
                end
            end
            send_text();
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_strings(220);
        calm = 1'b1;
        test_random_strings(50);
        drain_units();

        $display("Run covered %0d bytes in %0d strings, %0d UTF-16 units checked.",
                 bytes_sent, strings_sent, units_checked);
        $display("Units carrying the CESU-8 flag: %0d, mismatches: %0d.",
                 cesu_units, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/utf8d_pkg.sv
rtl/utf8d_core.sv
rtl/utf8_to_utf16_decoder.sv
tb/sv/tb_top.sv
